// ===== rtl/core/eno_pkg.sv =====
// ----------------------------------------------------------------------------
// eno_pkg
// Types and constants shared by the ENO stencil select core and its checker.
// ----------------------------------------------------------------------------
package eno_pkg;

    localparam int POS_W  = 12;
    localparam int SMP_W  = 32;
    localparam int ORD_W  = 2;
    localparam int D1_W   = SMP_W + 1;   // signed first difference
    localparam int D2_W   = SMP_W + 3;   // signed second difference
    localparam int A1_W   = SMP_W;       // magnitude of a first difference
    localparam int A2_W   = SMP_W + 2;   // magnitude of a second difference

    localparam logic [ORD_W-1:0] REQ_ORDER_RST = 2'd3;

    typedef struct packed {
        logic        [POS_W-1:0] center_pos;
        logic        [POS_W-1:0] low_bound;
        logic        [POS_W-1:0] high_bound;
        logic signed [SMP_W-1:0] sample_m2;
        logic signed [SMP_W-1:0] sample_m1;
        logic signed [SMP_W-1:0] sample_c;
        logic signed [SMP_W-1:0] sample_p1;
        logic signed [SMP_W-1:0] sample_p2;
    } eno_in_t;

    typedef struct packed {
        logic [1:0]       left_shift;
        logic [ORD_W-1:0] order_used;
        logic             bad_window;
    } eno_out_t;

    // Bound checks travel down the pipeline next to the differences
    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             bad;
        logic             c_eq_lo;    // center == low bound
        logic             c_eq_hi;    // center == high bound
        logic             cm1_eq_lo;  // center - 1 == low bound
        logic             cp1_eq_hi;  // center + 1 == high bound
    } eno_ctl_t;

endpackage

// ===== rtl/core/eno_stencil_select_core.sv =====
// ----------------------------------------------------------------------------
// eno_stencil_select_core
// ENO adaptive stencil selection on a five-sample window with bound limits.
// ----------------------------------------------------------------------------
// Takes one beat per clock; busy stays low and every accepted beat returns
// one result, strobed by result_valid for a single cycle, once the beat has
// passed the four register stages in order: difference formation, magnitude,
// compare, and final shift selection. The receiver cannot stall, so nothing
// ever holds the pipeline.
module eno_stencil_select_core
    import eno_pkg::*;
#(
    parameter int MAX_ORDER = 3,
    parameter int POS_BITS  = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [ORD_W-1:0]     cfg_wr_data,
    input  logic                 start,
    output logic                 busy,
    input  eno_in_t              item,
    output logic                 result_valid,
    output eno_out_t             result
);

    localparam int PB = (POS_BITS < POS_W) ? POS_BITS : POS_W;
    localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(MAX_ORDER);

    function automatic logic signed [D2_W-1:0] sx(input logic signed [SMP_W-1:0] v);
        sx = {{(D2_W-SMP_W){v[SMP_W-1]}}, v};
    endfunction

    function automatic logic [D2_W-1:0] mag(input logic signed [D2_W-1:0] v);
        mag = v[D2_W-1] ? D2_W'(-v) : D2_W'(v);
    endfunction

    logic [ORD_W-1:0] req_order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_order_reg <= REQ_ORDER_RST;
        end
        else if (cfg_wr_en)
        begin
            req_order_reg <= cfg_wr_data;
        end
    end

    assign busy = 1'b0;

    // ---------------- stage 1: bounds and differences ----------------
    logic [PB:0]        c_x, lo_x, hi_x, span;
    logic [ORD_W-1:0]   ord_req;
    logic [2:0]         avail;
    eno_ctl_t           ctl1_next;
    logic signed [D2_W-1:0] d1l_next, d1r_next, d20_next, d21_next, d22_next;

    always_comb
    begin
        c_x  = {1'b0, item.center_pos[PB-1:0]};
        lo_x = {1'b0, item.low_bound[PB-1:0]};
        hi_x = {1'b0, item.high_bound[PB-1:0]};
        span = hi_x - lo_x;
        ord_req = (req_order_reg > MAX_ORD) ? MAX_ORD : req_order_reg;
        avail = {1'b0, span[1:0]} + 3'd1;
        ctl1_next.order = ord_req;
        if (hi_x < lo_x)
        begin
            ctl1_next.order = '0;
        end
        else if (span < (PB+1)'(3) && avail < {1'b0, ord_req})
        begin
            ctl1_next.order = avail[ORD_W-1:0];
        end
        ctl1_next.bad       = (c_x < lo_x) || (c_x > hi_x);
        ctl1_next.c_eq_lo   = (c_x == lo_x);
        ctl1_next.c_eq_hi   = (c_x == hi_x);
        ctl1_next.cm1_eq_lo = (c_x == lo_x + (PB+1)'(1));
        ctl1_next.cp1_eq_hi = (c_x + (PB+1)'(1) == hi_x);

        d1l_next = sx(item.sample_c)  - sx(item.sample_m1);
        d1r_next = sx(item.sample_p1) - sx(item.sample_c);
        d20_next = sx(item.sample_c)  - (sx(item.sample_m1) <<< 1) + sx(item.sample_m2);
        d21_next = sx(item.sample_p1) - (sx(item.sample_c)  <<< 1) + sx(item.sample_m1);
        d22_next = sx(item.sample_p2) - (sx(item.sample_p1) <<< 1) + sx(item.sample_c);
    end

    logic                   v1_reg;
    eno_ctl_t               ctl1_reg;
    logic signed [D1_W-1:0] d1l_reg, d1r_reg;
    logic signed [D2_W-1:0] d20_reg, d21_reg, d22_reg;

    // ---------------- stage 2: magnitudes ----------------
    logic                   v2_reg;
    eno_ctl_t               ctl2_reg;
    logic [A1_W-1:0]        a1l_reg, a1r_reg;
    logic [A2_W-1:0]        a20_reg, a21_reg, a22_reg;
    logic [D2_W-1:0]        m1l, m1r, m20, m21, m22;

    assign m1l = mag(D2_W'(d1l_reg));
    assign m1r = mag(D2_W'(d1r_reg));
    assign m20 = mag(d20_reg);
    assign m21 = mag(d21_reg);
    assign m22 = mag(d22_reg);

    // ---------------- stage 3: compares ----------------
    logic                   v3_reg;
    eno_ctl_t               ctl3_reg;
    logic                   take1_reg;   // first order, left wins
    logic                   take20_reg;  // second order after no shift
    logic                   take21_reg;  // second order after one shift

    // ---------------- stage 4: shift select ----------------
    logic [1:0]             sh1, shift_next;
    logic                   pos_lo, pos_hi, take2;

    always_comb
    begin
        sh1 = 2'd0;
        if (ctl3_reg.c_eq_lo)
        begin
            sh1 = 2'd0;
        end
        else if (ctl3_reg.c_eq_hi || take1_reg)
        begin
            sh1 = 2'd1;
        end
        pos_lo = (sh1 == 2'd0) ? ctl3_reg.c_eq_lo   : ctl3_reg.cm1_eq_lo;
        pos_hi = (sh1 == 2'd0) ? ctl3_reg.cp1_eq_hi : ctl3_reg.c_eq_hi;
        take2  = (sh1 == 2'd0) ? take20_reg : take21_reg;
        shift_next = 2'd0;
        if (!ctl3_reg.bad && ctl3_reg.order >= 2'd2)
        begin
            shift_next = sh1;
            if (ctl3_reg.order == 2'd3 && !pos_lo && (pos_hi || take2))
            begin
                shift_next = sh1 + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            v1_reg       <= start && !busy;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            result_valid <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            ctl1_reg <= ctl1_next;
            d1l_reg  <= d1l_next[D1_W-1:0];
            d1r_reg  <= d1r_next[D1_W-1:0];
            d20_reg  <= d20_next;
            d21_reg  <= d21_next;
            d22_reg  <= d22_next;
        end
        if (v1_reg)
        begin
            ctl2_reg <= ctl1_reg;
            a1l_reg  <= m1l[A1_W-1:0];
            a1r_reg  <= m1r[A1_W-1:0];
            a20_reg  <= m20[A2_W-1:0];
            a21_reg  <= m21[A2_W-1:0];
            a22_reg  <= m22[A2_W-1:0];
        end
        if (v2_reg)
        begin
            ctl3_reg   <= ctl2_reg;
            take1_reg  <= {1'b0, a1l_reg} < {a1r_reg, 1'b0};
            take20_reg <= {1'b0, a21_reg} < {a22_reg, 1'b0};
            take21_reg <= {a20_reg, 1'b0} < {1'b0, a21_reg};
        end
        if (v3_reg)
        begin
            result.left_shift <= shift_next;
            result.order_used <= ctl3_reg.order;
            result.bad_window <= ctl3_reg.bad;
        end
    end

endmodule

// ===== rtl/core/eno_ssel_chk.sv =====
// ----------------------------------------------------------------------------
// eno_ssel_chk
// Port-level checks for the ENO stencil select core, bound to the core module.
// ----------------------------------------------------------------------------
module eno_ssel_chk
    import eno_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     result_valid,
    input eno_out_t result
);

    // every accepted beat comes back as a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 result_valid)
        else $error("result missing four cycles after accept");

    // no result without an accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 4))
        else $error("result without matching accept");

    a_bad_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.bad_window) |-> (result.left_shift == 2'd0))
        else $error("nonzero shift on bad window");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.left_shift == 2'd0 ||
                          result.left_shift < result.order_used))
        else $error("shift reaches past the stencil");

endmodule

bind eno_stencil_select_core eno_ssel_chk u_eno_ssel_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
